/* design/pvcf_pkg.sv */
// ----------------------------------------------------------------------------
// pvcf_pkg: shared types, constants and Q16.16 helpers
// Saturation, magnitude and sign-restore functions, register indexes and the
// sequencer state type of the plastic viscoelastic contact force block.
// ----------------------------------------------------------------------------
`default_nettype none

package pvcf_pkg;

  localparam int unsigned CONTACTS_DEF = 1024;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 31;
  localparam int unsigned DIV_STEPS = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_K1  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_K2M = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KC  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_D   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_P   = 3'd4;

  localparam logic [CFG_W-1:0] K1_RST  = 31'd65536;
  localparam logic [CFG_W-1:0] K2M_RST = 31'd327680;
  localparam logic [CFG_W-1:0] KC_RST  = 31'd0;
  localparam logic [CFG_W-1:0] D_RST   = 31'd0;
  localparam logic [CFG_W-1:0] P_RST   = 31'd6554;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_IDX, S_DIVRUN, S_RD, S_RDW,
    S_DIA_MUL, S_DIA_DIV, S_DIA_GET,
    S_K_DIV, S_K_M1, S_K_M2, S_DS_GET,
    S_K2_DIV, S_K2_MUL, S_K2_GET,
    S_E_DIV, S_E_MUL, S_DIFF, S_U_MUL, S_U_GET,
    S_EL1, S_EL2, S_M_DIV, S_M_MUL, S_M_GET,
    S_DV, S_FORCE, S_OUT
  } st_e;

  // Clamp a 33-bit sum to the signed 32-bit range.
  function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
    logic signed [31:0] r;
    if (x[32] != x[31]) begin
      r = x[32] ? Q_MIN : Q_MAX;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  // Apply a sign to an unsigned magnitude and saturate.
  function automatic logic signed [31:0] from_mag(input logic [47:0] m, input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      r = (m >= 48'h0000_8000_0000) ? Q_MIN : (~m[31:0] + 32'd1);
    end else begin
      r = (m > 48'h0000_7FFF_FFFF) ? Q_MAX : m[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [32:0] sx33(input logic signed [31:0] x);
    return {x[31], x};
  endfunction

endpackage

`default_nettype wire

/* design/pvcf_in_if.sv */
// ----------------------------------------------------------------------------
// pvcf_in_if: contact item channel
// Valid/ready channel that carries one contact item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface pvcf_in_if;
  logic               valid;
  logic               ready;
  logic [9:0]         contact_id;
  logic               new_contact;
  logic signed [31:0] overlap;
  logic signed [31:0] normal_velocity;
  logic [30:0]        radius_p;
  logic [30:0]        radius_i;
  logic               is_wall;

  modport source (
    output valid, contact_id, new_contact, overlap, normal_velocity,
           radius_p, radius_i, is_wall,
    input  ready
  );
  modport sink (
    input  valid, contact_id, new_contact, overlap, normal_velocity,
           radius_p, radius_i, is_wall,
    output ready
  );
endinterface

`default_nettype wire

/* design/pvcf_out_if.sv */
// ----------------------------------------------------------------------------
// pvcf_out_if: force result channel
// Valid/ready channel that carries one force result per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface pvcf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] normal_force;
  logic [30:0]        abs_force;
  logic               in_contact;
  logic               divide_fault;

  modport source (
    output valid, normal_force, abs_force, in_contact, divide_fault,
    input  ready
  );
  modport sink (
    input  valid, normal_force, abs_force, in_contact, divide_fault,
    output ready
  );
endinterface

`default_nettype wire

/* design/plastic_viscoelastic_contact_force.sv */
// ----------------------------------------------------------------------------
// plastic_viscoelastic_contact_force: hysteretic contact normal force
// Sequenced Q16.16 datapath around one multiplier, one radix-2 divider and a
// history memory holding a per-contact maximum-overlap history value.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one contact item per transfer (id, new-contact flag, overlap,
//            normal velocity, two radii, wall flag).
//   out_ch : one result per item (signed force, absolute force, contact and
//            divide-fault flags), held in an output register.
//   cfg_*  : stiffnesses, damping and plastic depth; write only while idle.
// After reset the history memory is cleared one entry per cycle, all CONTACTS
// entries, with in_ch.ready low; configuration writes are taken meanwhile.
// Items are handled one at a time. Every division runs through the shared
// divider at one quotient bit per cycle; the contact index is reduced
// modulo CONTACTS by a reciprocal multiply.
// An item without contact goes from the memory read straight to the output
// step; a particle contact on the cohesive branch runs five divisions.
// A new item is taken while a finished result still waits in the output
// register; when the receiver stalls, the next result holds in its final
// step until the output register frees, and then in_ch.ready returns.
// ----------------------------------------------------------------------------
`default_nettype none

module plastic_viscoelastic_contact_force
  import pvcf_pkg::*;
#(
  parameter int unsigned CONTACTS = CONTACTS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  pvcf_in_if.sink                   in_ch,
  pvcf_out_if.source                out_ch
);

  localparam int unsigned AW = (CONTACTS > 1) ? $clog2(CONTACTS) : 1;

  // reciprocal of CONTACTS, exact quotient for any 10-bit contact id
  localparam int unsigned IDX_SH = 20;
  localparam logic [20:0] IDX_RCP =
    21'(((64'd1 << IDX_SH) + 64'(CONTACTS) - 64'd1) / 64'(CONTACTS));

  // configuration registers
  logic [CFG_W-1:0] k1_q, k2m_q, kc_q, d_q, p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_q  <= K1_RST;
      k2m_q <= K2M_RST;
      kc_q  <= KC_RST;
      d_q   <= D_RST;
      p_q   <= P_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_K1:  k1_q  <= cfg_data_i;
        CFG_K2M: k2m_q <= cfg_data_i;
        CFG_KC:  kc_q  <= cfg_data_i;
        CFG_D:   d_q   <= cfg_data_i;
        CFG_P:   p_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [31:0] k1_s, k2m_s, kc_s, d_s, p_s;
  assign k1_s  = {1'b0, k1_q};
  assign k2m_s = {1'b0, k2m_q};
  assign kc_s  = {1'b0, kc_q};
  assign d_s   = {1'b0, d_q};
  assign p_s   = {1'b0, p_q};

  // state
  st_e state_q, state_d, ret_q, ret_d;
  logic [AW-1:0] clr_q, clr_d;

  // latched item
  logic [9:0]         id_q;
  logic               nc_q, wall_q;
  logic signed [31:0] ov_q, v_q;
  logic [30:0]        rp_q, ri_q;

  // working registers
  logic [AW-1:0]      idx_q, idx_d;
  logic signed [31:0] stored_q, stored_d, dia_q, dia_d, ds_q, ds_d, m_q, m_d;
  logic signed [31:0] k2_q, k2_d, diff_q, diff_d, u_q, u_d, el_q, el_d;
  logic signed [31:0] force_q, force_d;
  logic               big_q, big_d, fault_q, fault_d, contact_q, contact_d;

  // contact index reduction
  logic [29:0]        idx_prod;
  logic [9:0]         idx_quo;
  logic [26:0]        idx_rem;

  // multiplier
  logic               mul_go;
  logic signed [31:0] ma, mb;
  logic [63:0]        prod_q;
  logic               mneg_q;
  logic signed [31:0] mul_res;

  // divider
  logic               div_go;
  logic signed [31:0] da, db;
  logic [47:0]        dvd_q, dvd_d, quo_q, quo_d;
  logic [31:0]        dvs_q, dvs_d, rem_q, rem_d;
  logic [5:0]         cnt_q, cnt_d;
  logic               dneg_q, dneg_d, dz_q, dz_d;
  logic [32:0]        trial;
  logic signed [31:0] div_res;

  // memory
  logic [31:0]   mem_q [CONTACTS];
  logic [31:0]   rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata;

  // output register
  logic               ovalid_q;
  logic signed [31:0] onf_q;
  logic [30:0]        oabs_q;
  logic               oin_q, oflt_q;
  logic               out_free, out_load;

  assign out_free = !ovalid_q || out_ch.ready;
  assign out_load = (state_q == S_OUT) && out_free;
  assign in_ch.ready = (state_q == S_IDLE);

  assign mul_res = from_mag(prod_q[63:16], mneg_q);
  assign div_res = dz_q ? 32'sd0 : from_mag(quo_q, dneg_q);
  assign trial   = {rem_q, dvd_q[47]} - {1'b0, dvs_q};

  assign idx_prod = {20'd0, id_q} * {9'd0, IDX_RCP};
  assign idx_quo  = idx_prod[IDX_SH+9:IDX_SH];
  assign idx_rem  = {17'd0, id_q} - {17'd0, idx_quo} * 27'(CONTACTS);

  // derived operands
  logic signed [31:0] kd, s2rp, srpri, k2mk1, k2pkc, k1pm, neg_mr, neg_force, abs_s;
  logic               ge1, ge2, ds_big;
  assign kd     = sat33(sx33(k2m_s) - sx33(k1_s));
  assign s2rp   = sat33({1'b0, rp_q, 1'b0});
  assign srpri  = sat33({2'b0, rp_q} + {2'b0, ri_q});
  assign k2mk1  = sat33(sx33(k2_q) - sx33(k1_s));
  assign k2pkc  = sat33(sx33(k2_q) + sx33(kc_s));
  assign k1pm   = sat33(sx33(k1_s) + sx33(mul_res));
  assign neg_mr = sat33(-sx33(mul_res));
  assign ge1    = u_q >= mul_res;
  assign ge2    = u_q >= neg_mr;
  assign ds_big = ov_q > mul_res;
  assign neg_force = sat33(-sx33(force_q));
  assign abs_s  = force_q[31] ? neg_force : force_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:   if (clr_q == AW'(CONTACTS - 1)) state_d = S_IDLE;
      S_IDLE:    if (in_ch.valid) state_d = S_IDX;
      S_IDX:     state_d = S_RD;
      S_DIVRUN:  if (cnt_q == 6'd1) state_d = ret_q;
      S_RD:      state_d = S_RDW;
      S_RDW: begin
        if (ov_q <= 32'sd0) state_d = S_OUT;
        else if (wall_q)    state_d = S_K_DIV;
        else                state_d = S_DIA_MUL;
      end
      S_DIA_MUL: state_d = S_DIA_DIV;
      S_DIA_DIV: state_d = S_DIVRUN;
      S_DIA_GET: state_d = S_K_DIV;
      S_K_DIV:   state_d = S_DIVRUN;
      S_K_M1:    state_d = S_K_M2;
      S_K_M2:    state_d = S_DS_GET;
      S_DS_GET:  state_d = ds_big ? S_E_DIV : S_K2_DIV;
      S_K2_DIV:  state_d = S_DIVRUN;
      S_K2_MUL:  state_d = S_K2_GET;
      S_K2_GET:  state_d = S_E_DIV;
      S_E_DIV:   state_d = S_DIVRUN;
      S_E_MUL:   state_d = S_DIFF;
      S_DIFF:    state_d = S_U_MUL;
      S_U_MUL:   state_d = S_U_GET;
      S_U_GET:   state_d = S_EL1;
      S_EL1:     state_d = (big_q || ge1) ? S_DV : S_EL2;
      S_EL2:     state_d = ge2 ? S_DV : S_M_DIV;
      S_M_DIV:   state_d = S_DIVRUN;
      S_M_MUL:   state_d = S_M_GET;
      S_M_GET:   state_d = S_DV;
      S_DV:      state_d = S_FORCE;
      S_FORCE:   state_d = S_OUT;
      S_OUT:     if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    ret_d = ret_q;      clr_d = clr_q;      idx_d = idx_q;
    stored_d = stored_q; dia_d = dia_q;    ds_d = ds_q;     m_d = m_q;
    k2_d = k2_q;        diff_d = diff_q;    u_d = u_q;       el_d = el_q;
    force_d = force_q;  big_d = big_q;      fault_d = fault_q;
    contact_d = contact_q;
    mul_go = 1'b0; ma = '0; mb = '0;
    div_go = 1'b0; da = '0; db = '0;
    mem_re = 1'b0; mem_raddr = idx_q;
    mem_we = 1'b0; mem_waddr = idx_q; mem_wdata = '0;

    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1; mem_waddr = clr_q; clr_d = clr_q + AW'(1);
      end
      S_IDLE: begin
        fault_d = 1'b0;
      end
      S_IDX: begin
        idx_d = idx_rem[AW-1:0];
      end
      S_RD: begin
        mem_re = 1'b1;
      end
      S_RDW: begin
        stored_d  = nc_q ? 32'sd0 : rdata_q;
        dia_d     = s2rp;
        contact_d = (ov_q > 32'sd0);
        force_d   = '0;
      end
      S_DIA_MUL: begin
        mul_go = 1'b1; ma = s2rp; mb = {1'b0, ri_q};
      end
      S_DIA_DIV: begin
        div_go = 1'b1; da = mul_res; db = srpri; ret_d = S_DIA_GET;
      end
      S_DIA_GET: dia_d = div_res;
      S_K_DIV: begin
        div_go = 1'b1; da = k2m_s; db = kd; ret_d = S_K_M1;
      end
      S_K_M1: begin
        mul_go = 1'b1; ma = div_res; mb = p_s;
      end
      S_K_M2: begin
        mul_go = 1'b1; ma = mul_res; mb = dia_q;
      end
      S_DS_GET: begin
        // clamp the history to the fluid limit
        ds_d  = mul_res;
        big_d = ds_big;
        m_d   = (stored_q > ov_q) ? stored_q : ov_q;
        if (mul_res < m_d) m_d = mul_res;
        if (ds_big) k2_d = k2m_s;
      end
      S_K2_DIV: begin
        div_go = 1'b1; da = m_q; db = ds_q; ret_d = S_K2_MUL;
      end
      S_K2_MUL: begin
        mul_go = 1'b1; ma = kd; mb = div_res;
      end
      S_K2_GET: k2_d = k1pm;
      S_E_DIV: begin
        div_go = 1'b1; da = k2mk1; db = k2_q; ret_d = S_E_MUL;
      end
      S_E_MUL: begin
        mul_go = 1'b1; ma = div_res; mb = m_q;
      end
      S_DIFF:  diff_d = sat33(sx33(ov_q) - sx33(mul_res));
      S_U_MUL: begin
        mul_go = 1'b1; ma = k2_q; mb = diff_q;
      end
      S_U_GET: begin
        u_d = mul_res; mul_go = 1'b1;
        ma = big_q ? k2m_s : k1_s;
        mb = big_q ? diff_q : ov_q;
      end
      S_EL1: begin
        el_d = mul_res;
        if (!big_q && !ge1) begin
          mul_go = 1'b1; ma = kc_s; mb = ov_q;
        end
      end
      S_EL2: begin
        // cohesive branch rewrites the history
        el_d = ge2 ? u_q : neg_mr;
      end
      S_M_DIV: begin
        div_go = 1'b1; da = k2pkc; db = k2mk1; ret_d = S_M_MUL;
      end
      S_M_MUL: begin
        mul_go = 1'b1; ma = div_res; mb = ov_q;
      end
      S_M_GET: m_d = mul_res;
      S_DV: begin
        mul_go = 1'b1; ma = d_s; mb = v_q;
      end
      S_FORCE: begin
        force_d = fault_q ? 32'sd0 : sat33(sx33(neg_mr) + sx33(el_q));
      end
      S_OUT: begin
        // a new contact clears the entry even when the item faulted
        if (out_free) begin
          mem_we    = (contact_q && !fault_q) || nc_q;
          mem_wdata = (contact_q && !fault_q) ? m_q : 32'd0;
        end
      end
      default: ;
    endcase
  end

  // divider step
  always_comb begin
    dvd_d = dvd_q; dvs_d = dvs_q; rem_d = rem_q; quo_d = quo_q;
    cnt_d = cnt_q; dneg_d = dneg_q; dz_d = dz_q;
    if (div_go) begin
      cnt_d  = 6'(DIV_STEPS);
      rem_d  = '0;
      quo_d  = '0;
      dvd_d  = {mag32(da), 16'd0};
      dvs_d  = mag32(db);
      dneg_d = da[31] ^ db[31];
      dz_d   = (db == 32'sd0);
    end else if (state_q == S_DIVRUN) begin
      cnt_d = cnt_q - 6'd1;
      dvd_d = {dvd_q[46:0], 1'b0};
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], dvd_q[47]};
        quo_d = {quo_q[46:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      ret_q    <= S_IDLE;
      clr_q    <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
      fault_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      fault_q <= (div_go && db == 32'sd0) ? 1'b1 : fault_d;
      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      id_q   <= in_ch.contact_id;
      nc_q   <= in_ch.new_contact;
      ov_q   <= in_ch.overlap;
      v_q    <= in_ch.normal_velocity;
      rp_q   <= in_ch.radius_p;
      ri_q   <= in_ch.radius_i;
      wall_q <= in_ch.is_wall;
    end
    idx_q <= idx_d;  stored_q <= stored_d; dia_q <= dia_d; ds_q <= ds_d;
    m_q <= m_d;      k2_q <= k2_d;         diff_q <= diff_d; u_q <= u_d;
    el_q <= el_d;    force_q <= force_d;   big_q <= big_d;
    contact_q <= contact_d;
    dvd_q <= dvd_d;  dvs_q <= dvs_d;  rem_q <= rem_d;  quo_q <= quo_d;
    dneg_q <= dneg_d; dz_q <= dz_d;
    if (mul_go) begin
      prod_q <= mag32(ma) * mag32(mb);
      mneg_q <= ma[31] ^ mb[31];
    end
    if (out_load) begin
      onf_q  <= force_q;
      oabs_q <= abs_s[30:0];
      oin_q  <= contact_q;
      oflt_q <= fault_q;
    end
  end

  // history memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign out_ch.valid        = ovalid_q;
  assign out_ch.normal_force = onf_q;
  assign out_ch.abs_force    = oabs_q;
  assign out_ch.in_contact   = oin_q;
  assign out_ch.divide_fault = oflt_q;

  // checks
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVRUN) |-> (cnt_q != 6'd0))
    else $error("divider running with zero step count");

  a_mem_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLEAR || state_q == S_OUT))
    else $error("history write outside clear or result step");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.divide_fault) |->
      (out_ch.normal_force == 32'sd0 && out_ch.in_contact))
    else $error("faulted result carries force");

  a_nocontact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.in_contact) |->
      (out_ch.normal_force == 32'sd0 && !out_ch.divide_fault))
    else $error("result without contact is not zero");

  a_load_after_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_ch.valid)
    else $error("loaded result not presented");

endmodule

`default_nettype wire
